// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the slot allocator.
// Every macro samples on clk_i and is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/nfsa_pkg.sv -----
// Package of the nearest free slot allocator: field widths, command and
// status codes, and the packed item types of both channels. No dependencies.
package nfsa_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned LABEL_W = 16;
  localparam int unsigned COST_W  = 16;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_ALLOC   = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_LOOKUP  = 2'd3
  } cmd_kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } rsp_status_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [LABEL_W-1:0]   slot_label;
    logic [COST_W-1:0]    slot_cost;
    logic [KEY_W-1:0]     owner_key;
  } nfsa_cmd_t;

  typedef struct packed {
    rsp_status_e          status;
    logic [LABEL_W-1:0]   found_label;
    logic [COST_W-1:0]    found_cost;
  } nfsa_rsp_t;

endpackage

// ----- rtl/nfsa_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; used for the slot table and the key list of the allocator.
module nfsa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/nearest_free_slot_allocator.sv -----
// Top level of the nearest free slot allocator: command sequencer, busy flags,
// one compare unit shared by all scans. Depends on nfsa_pkg, nfsa_ram and assert_macros.svh.
//
//   Channel | Direction | Handshake                 | Item type
//   --------+-----------+---------------------------+-----------
//   in      | input     | in_valid_i / in_ready_o   | nfsa_cmd_t
//   out     | output    | out_valid_o / out_ready_i | nfsa_rsp_t
//
// One command is worked at a time; in_ready_o is high only while the sequencer is idle.
// Add needs no scan; allocate walks the defined slots, look up walks the key list up to
// the matching entry, and release walks the whole key list, shifting the later entries down.
// The walks come from the single read port of each RAM, which the compare unit walks one entry a cycle.
// A finished item waits in the output register, so a new command is taken while it stalls.
// Reset clears the counts and busy flags at once; the RAM contents need no clearing.
`include "assert_macros.svh"

module nearest_free_slot_allocator import nfsa_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  nfsa_cmd_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output nfsa_rsp_t out_data_o
);

  localparam int unsigned IDX_W  = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int unsigned SLOT_W = LABEL_W + COST_W;
  localparam int unsigned KENT_W = KEY_W + IDX_W;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_SCAN_SLOT = 7'b0000010,
    S_SCAN_KEY  = 7'b0000100,
    S_READ_SLOT = 7'b0001000,
    S_SLOT_DATA = 7'b0010000,
    S_SHIFT     = 7'b0100000,
    S_RESP      = 7'b1000000
  } state_e;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        ptr_q, ptr_d;
  logic                    chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]        chk_idx_q, chk_idx_d;
  logic                    have_q, have_d;
  logic [CNT_W-1:0]        slots_q, slots_d;
  logic [CNT_W-1:0]        keys_q, keys_d;
  logic [SLOT_COUNT-1:0]   busy_q, busy_d;
  logic                    out_valid_q, out_valid_d;

  logic [IDX_W-1:0]        best_idx_q, best_idx_d;
  logic [LABEL_W-1:0]      best_label_q, best_label_d;
  logic [COST_W-1:0]       best_cost_q, best_cost_d;
  logic [IDX_W-1:0]        pos_q, pos_d;
  logic [IDX_W-1:0]        sel_q, sel_d;
  nfsa_cmd_t               cmd_q, cmd_d;
  nfsa_rsp_t               res_q, res_d;
  nfsa_rsp_t               out_q, out_d;

  logic                    issue;
  logic                    slot_we;
  logic [IDX_W-1:0]        slot_waddr, slot_raddr;
  logic [SLOT_W-1:0]       slot_wdata, slot_rdata;
  logic                    key_we;
  logic [IDX_W-1:0]        key_waddr, key_raddr;
  logic [KENT_W-1:0]       key_wdata, key_rdata;

  logic [LABEL_W-1:0]      rd_label;
  logic [COST_W-1:0]       rd_cost;
  logic [KEY_W-1:0]        rd_key;
  logic [IDX_W-1:0]        rd_slot;

  assign rd_label = slot_rdata[SLOT_W-1:COST_W];
  assign rd_cost  = slot_rdata[COST_W-1:0];
  assign rd_key   = key_rdata[KENT_W-1:IDX_W];
  assign rd_slot  = key_rdata[IDX_W-1:0];

  // Slot table: label and cost per slot.
  nfsa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // Ordered key list: key and the slot it holds.
  nfsa_ram #(
    .WIDTH (KENT_W),
    .DEPTH (SLOT_COUNT)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  // Sequencer. Scans issue one RAM read per cycle; the compare unit looks at the
  // entry read in the previous cycle, tagged by chk_vld_q and chk_idx_q.
  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = ptr_q[IDX_W-1:0];
    have_d       = have_q;
    slots_d      = slots_q;
    keys_d       = keys_q;
    busy_d       = busy_q;
    out_valid_d  = out_valid_q;
    best_idx_d   = best_idx_q;
    best_label_d = best_label_q;
    best_cost_d  = best_cost_q;
    pos_d        = pos_q;
    sel_d        = sel_q;
    cmd_d        = cmd_q;
    res_d        = res_q;
    out_d        = out_q;
    issue        = 1'b0;
    slot_we      = 1'b0;
    slot_waddr   = slots_q[IDX_W-1:0];
    slot_wdata   = {in_data_i.slot_label, in_data_i.slot_cost};
    slot_raddr   = ptr_q[IDX_W-1:0];
    key_we       = 1'b0;
    key_waddr    = keys_q[IDX_W-1:0];
    key_wdata    = {cmd_q.owner_key, best_idx_q};
    key_raddr    = ptr_q[IDX_W-1:0];

    // The output register drains independently of the sequencer.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = in_data_i;
          ptr_d  = '0;
          have_d = 1'b0;
          unique case (in_data_i.kind)
            KIND_ADD: begin
              if (slots_q == CNT_W'(SLOT_COUNT)) begin
                res_d = '{status: ST_FULL, found_label: '0, found_cost: '0};
              end else begin
                slot_we                        = 1'b1;
                busy_d[slots_q[IDX_W-1:0]]     = 1'b0;
                slots_d                        = slots_q + CNT_W'(1);
                res_d = '{status: ST_OK, found_label: '0, found_cost: '0};
              end
              state_d = S_RESP;
            end
            KIND_ALLOC: begin
              state_d = S_SCAN_SLOT;
            end
            KIND_RELEASE, KIND_LOOKUP: begin
              state_d = S_SCAN_KEY;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // Least-cost search over the free defined slots; a strict compare keeps the lowest index on a tie.
      S_SCAN_SLOT: begin
        issue     = (ptr_q < slots_q);
        chk_vld_d = issue;
        if (issue) begin
          ptr_d = ptr_q + CNT_W'(1);
        end
        if (chk_vld_q && !busy_q[chk_idx_q] && (!have_q || rd_cost < best_cost_q)) begin
          have_d       = 1'b1;
          best_idx_d   = chk_idx_q;
          best_label_d = rd_label;
          best_cost_d  = rd_cost;
        end
        if (!issue && !chk_vld_q) begin
          if (have_q && keys_q < CNT_W'(SLOT_COUNT)) begin
            key_we             = 1'b1;
            busy_d[best_idx_q] = 1'b1;
            keys_d             = keys_q + CNT_W'(1);
            res_d = '{status: ST_OK, found_label: best_label_q, found_cost: best_cost_q};
          end else begin
            res_d = '{status: ST_NO_FREE, found_label: '0, found_cost: '0};
          end
          state_d = S_RESP;
        end
      end

      // Search for the earliest key entry that matches.
      S_SCAN_KEY: begin
        issue     = (ptr_q < keys_q);
        chk_vld_d = issue;
        if (issue) begin
          ptr_d = ptr_q + CNT_W'(1);
        end
        if (chk_vld_q && rd_key == cmd_q.owner_key) begin
          pos_d     = chk_idx_q;
          sel_d     = rd_slot;
          chk_vld_d = 1'b0;
          state_d   = S_READ_SLOT;
        end else if (!issue && !chk_vld_q) begin
          res_d   = '{status: ST_NOT_FOUND, found_label: '0, found_cost: '0};
          state_d = S_RESP;
        end
      end

      S_READ_SLOT: begin
        slot_raddr = sel_q;
        state_d    = S_SLOT_DATA;
      end

      // Look up reports the slot; release frees it and starts closing the gap.
      S_SLOT_DATA: begin
        if (cmd_q.kind == KIND_LOOKUP) begin
          res_d   = '{status: ST_OK, found_label: rd_label, found_cost: rd_cost};
          state_d = S_RESP;
        end else begin
          res_d         = '{status: ST_OK, found_label: rd_label, found_cost: '0};
          busy_d[sel_q] = 1'b0;
          ptr_d         = CNT_W'(pos_q) + CNT_W'(1);
          state_d       = S_SHIFT;
        end
      end

      // Move each later key entry down by one place, keeping the order.
      S_SHIFT: begin
        issue     = (ptr_q < keys_q);
        chk_vld_d = issue;
        if (issue) begin
          ptr_d = ptr_q + CNT_W'(1);
        end
        if (chk_vld_q) begin
          key_we    = 1'b1;
          key_waddr = chk_idx_q - IDX_W'(1);
          key_wdata = key_rdata;
        end
        if (!issue && !chk_vld_q) begin
          keys_d  = keys_q - CNT_W'(1);
          state_d = S_RESP;
        end
      end

      // Hand the result to the output register once it is free.
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      chk_vld_q   <= 1'b0;
      chk_idx_q   <= '0;
      have_q      <= 1'b0;
      slots_q     <= '0;
      keys_q      <= '0;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      chk_vld_q   <= chk_vld_d;
      chk_idx_q   <= chk_idx_d;
      have_q      <= have_d;
      slots_q     <= slots_d;
      keys_q      <= keys_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    best_idx_q   <= best_idx_d;
    best_label_q <= best_label_d;
    best_cost_q  <= best_cost_d;
    pos_q        <= pos_d;
    sel_q        <= sel_d;
    cmd_q        <= cmd_d;
    res_q        <= res_d;
    out_q        <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Every key entry owns exactly one busy slot, so between commands the counts agree.
  `ASSERT_IMPLIES(a_busy_matches_keys, state_q == S_IDLE,
                  $countones(busy_q) == keys_q, "busy flags and key count disagree")
  // Keys can never outnumber the defined slots, nor the defined slots the table depth.
  `ASSERT_ALWAYS(a_keys_within_slots,
                 keys_q <= slots_q && slots_q <= CNT_W'(SLOT_COUNT),
                 "key or slot count out of range")
  // A pending compare only exists inside one of the scanning states.
  `ASSERT_IMPLIES(a_check_in_scan, chk_vld_q,
                  state_q == S_SCAN_SLOT || state_q == S_SCAN_KEY || state_q == S_SHIFT,
                  "compare pending outside a scan")

endmodule

// ----- dv/tb_nearest_free_slot_allocator.sv -----
`timescale 1ns / 100ps
// Testbench of the nearest free slot allocator: directed and random commands, checked
// against an in-bench model of the slot table and key list. Depends on nfsa_pkg and the RTL.
module tb_nearest_free_slot_allocator;
  import nfsa_pkg::*;

  localparam int SLOT_COUNT   = 16;
  localparam int SLOT_IDX_W   = $clog2(SLOT_COUNT);
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 2 * SLOT_COUNT + 20;
  localparam int RANDOM_ITEMS = 860;

  // One entry of the ordered key list.
  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [SLOT_IDX_W-1:0] slot;
  } holding_t;

  logic      clk;
  logic      rst_n;
  logic      cmd_valid;
  logic      cmd_ready;
  nfsa_cmd_t cmd_item;
  logic      rsp_valid;
  logic      rsp_ready;
  nfsa_rsp_t rsp_item;

  // Model of the slot table and the key list.
  logic [LABEL_W-1:0] tbl_label [SLOT_COUNT];
  logic [COST_W-1:0]  tbl_cost  [SLOT_COUNT];
  bit                 tbl_busy  [SLOT_COUNT];
  int                 tbl_count;
  holding_t           holdings[$];

  nfsa_rsp_t          pending_rsp[$];
  logic [KEY_W-1:0]   key_pool [8];
  int unsigned        err_count;
  int unsigned        rsp_count;
  int unsigned        cycle_count;
  int unsigned        hold_off_cycles;
  bit                 gapless;

  nearest_free_slot_allocator #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (cmd_valid),
    .in_ready_o (cmd_ready),
    .in_data_i  (cmd_item),
    .out_valid_o(rsp_valid),
    .out_ready_i(rsp_ready),
    .out_data_o (rsp_item)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    err_count++;
    $display("[%0t] mismatch on response %0d: %s", $realtime, rsp_count, msg);
  endtask

  // Applies one command to the model and returns the response it must produce.
  function automatic nfsa_rsp_t predict_rsp(input nfsa_cmd_t cmd);
    nfsa_rsp_t rsp;
    holding_t  held;
    int        best;
    int        pos;
    rsp.status      = ST_OK;
    rsp.found_label = '0;
    rsp.found_cost  = '0;
    best = -1;
    pos  = -1;
    case (cmd.kind)
      KIND_ADD: begin
        if (tbl_count >= SLOT_COUNT) begin
          rsp.status = ST_FULL;
        end else begin
          tbl_label[tbl_count] = cmd.slot_label;
          tbl_cost[tbl_count]  = cmd.slot_cost;
          tbl_busy[tbl_count]  = 1'b0;
          tbl_count++;
        end
      end
      KIND_ALLOC: begin
        // Cheapest free slot; a strict compare keeps the lowest index on a tie.
        for (int i = 0; i < tbl_count; i++) begin
          if (!tbl_busy[i] && (best < 0 || tbl_cost[i] < tbl_cost[best])) best = i;
        end
        if (best < 0 || holdings.size() >= SLOT_COUNT) begin
          rsp.status = ST_NO_FREE;
        end else begin
          tbl_busy[best]  = 1'b1;
          held.key        = cmd.owner_key;
          held.slot       = best[SLOT_IDX_W-1:0];
          holdings.push_back(held);
          rsp.found_label = tbl_label[best];
          rsp.found_cost  = tbl_cost[best];
        end
      end
      default: begin
        // Release and look up act on the earliest matching key entry.
        for (int i = 0; i < holdings.size(); i++) begin
          if (pos < 0 && holdings[i].key == cmd.owner_key) pos = i;
        end
        if (pos < 0) begin
          rsp.status = ST_NOT_FOUND;
        end else begin
          held = holdings[pos];
          rsp.found_label = tbl_label[held.slot];
          if (cmd.kind == KIND_RELEASE) begin
            tbl_busy[held.slot] = 1'b0;
            holdings.delete(pos);
          end else begin
            rsp.found_cost = tbl_cost[held.slot];
          end
        end
      end
    endcase
    return rsp;
  endfunction

  // Predicts on each accepted command and checks each accepted response.
  always @(posedge clk) begin
    nfsa_rsp_t exp_rsp;
    if (rst_n) begin
      if (cmd_valid && cmd_ready) pending_rsp.push_back(predict_rsp(cmd_item));
      if (rsp_valid && rsp_ready) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("response with no command outstanding");
        end else begin
          exp_rsp = pending_rsp.pop_front();
          if (rsp_item.status !== exp_rsp.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      rsp_item.status, exp_rsp.status));
          if (rsp_item.found_label !== exp_rsp.found_label)
            report_mismatch($sformatf("label got %h expected %h",
                                      rsp_item.found_label, exp_rsp.found_label));
          if (rsp_item.found_cost !== exp_rsp.found_cost)
            report_mismatch($sformatf("cost got %h expected %h",
                                      rsp_item.found_cost, exp_rsp.found_cost));
        end
        rsp_count++;
      end
    end
  end

  // Response side: random ready pattern, plus a long hold-off when one is requested.
  initial begin
    int unsigned run_left;
    int unsigned pick;
    run_left  = 0;
    rsp_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        rsp_ready <= 1'b0;
        hold_off_cycles--;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          rsp_ready <= 1'b1;
          run_left = $urandom_range(1, 30);
        end else begin
          rsp_ready <= 1'b0;
          if (pick < 85) run_left = $urandom_range(0, 2);
          else if (pick < 97) run_left = $urandom_range(3, 12);
          else run_left = $urandom_range(20, 50);
        end
      end
    end
  end

  // Idle cycles between commands: mostly short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (gapless || pick < 40) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Offers one command and holds it until accepted, then idles for a random gap.
  task automatic send_cmd(input nfsa_cmd_t cmd);
    int unsigned gap;
    cmd_valid <= 1'b1;
    cmd_item  <= cmd;
    do @(posedge clk); while (!cmd_ready);
    gap = pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic nfsa_cmd_t make_cmd(input cmd_kind_e kind, input logic [15:0] label,
                                         input logic [15:0] cost, input logic [63:0] key);
    nfsa_cmd_t cmd;
    cmd.kind       = kind;
    cmd.slot_label = label;
    cmd.slot_cost  = cost;
    cmd.owner_key  = key;
    return cmd;
  endfunction

  // Mostly keys that are held or recur, so lookups and releases hit.
  function automatic logic [63:0] choose_key();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (holdings.size() > 0 && pick < 60)
      return holdings[$urandom_range(0, holdings.size() - 1)].key;
    if (pick < 85) return key_pool[$urandom_range(0, 7)];
    return {$urandom, $urandom};
  endfunction

  function automatic nfsa_cmd_t random_cmd();
    nfsa_cmd_t   cmd;
    int unsigned pick;
    cmd.slot_label = 16'($urandom);
    cmd.slot_cost  = 16'($urandom);
    cmd.owner_key  = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < ((tbl_count < SLOT_COUNT) ? 40 : 6)) begin
      cmd.kind = KIND_ADD;
      // Small costs make ties common.
      if ($urandom_range(0, 3) != 0) cmd.slot_cost = 16'($urandom_range(0, 7));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 40) cmd.kind = KIND_ALLOC;
      else cmd.kind = (pick < 72) ? KIND_RELEASE : KIND_LOOKUP;
      if ($urandom_range(0, 9) != 0) cmd.owner_key = choose_key();
    end
    return cmd;
  endfunction

  // Commands on an empty table find nothing.
  task automatic test_empty_table();
    send_cmd(make_cmd(KIND_ALLOC, 16'h1111, 16'h2222, 64'h0));
    send_cmd(make_cmd(KIND_RELEASE, 16'h0, 16'h0, '1));
    send_cmd(make_cmd(KIND_LOOKUP, 16'h0, 16'h0, 64'h0));
  endtask

  // Field extremes and a cost tie between slots one and two.
  task automatic test_add_extremes();
    send_cmd(make_cmd(KIND_ADD, 16'h0000, 16'hFFFF, '1));
    send_cmd(make_cmd(KIND_ADD, 16'hFFFF, 16'h0000, 64'h0));
    send_cmd(make_cmd(KIND_ADD, 16'h1234, 16'h0000, 64'h0));
    send_cmd(make_cmd(KIND_ADD, 16'hA5A5, 16'h0005, 64'h0));
  endtask

  // Allocation order, duplicate keys, release, look up and an exhausted table.
  task automatic test_alloc_release();
    send_cmd(make_cmd(KIND_ALLOC, 16'h0, 16'h0, 64'h0));
    send_cmd(make_cmd(KIND_ALLOC, 16'h0, 16'h0, '1));
    send_cmd(make_cmd(KIND_ALLOC, 16'h0, 16'h0, 64'h0));
    send_cmd(make_cmd(KIND_LOOKUP, 16'h0, 16'h0, 64'h0));
    send_cmd(make_cmd(KIND_RELEASE, 16'h0, 16'h0, 64'h0));
    send_cmd(make_cmd(KIND_LOOKUP, 16'h0, 16'h0, 64'h0));
    send_cmd(make_cmd(KIND_RELEASE, 16'h0, 16'h0, '1));
    send_cmd(make_cmd(KIND_RELEASE, 16'h0, 16'h0, '1));
    send_cmd(make_cmd(KIND_LOOKUP, 16'h0, 16'h0, 64'h8000_0000_0000_0001));
    repeat (3) send_cmd(make_cmd(KIND_ALLOC, 16'h0, 16'h0, 64'h7FFF_FFFF_FFFF_FFFE));
    send_cmd(make_cmd(KIND_ALLOC, 16'h0, 16'h0, 64'h5555_AAAA_5555_AAAA));
  endtask

  // Fills the table, then an add is refused.
  task automatic test_table_full();
    while (tbl_count < SLOT_COUNT)
      send_cmd(make_cmd(KIND_ADD, 16'($urandom), 16'($urandom_range(0, 7)), 64'h0));
    send_cmd(make_cmd(KIND_ADD, 16'hFFFF, 16'hFFFF, '1));
  endtask

  // The response side stalls for a long stretch while commands keep coming.
  task automatic test_output_backpressure();
    hold_off_cycles = 300;
    gapless = 1'b1;
    repeat (12) send_cmd(random_cmd());
    gapless = 1'b0;
  endtask

  // Random mix with gapless bursts now and then.
  task automatic test_random();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gapless = (i % 150) < 25;
      send_cmd(random_cmd());
    end
    gapless = 1'b0;
  endtask

  // Test sequence.
  initial begin
    cmd_valid       = 1'b0;
    cmd_item        = '0;
    rst_n           = 1'b0;
    tbl_count       = 0;
    err_count       = 0;
    rsp_count       = 0;
    cycle_count     = 0;
    hold_off_cycles = 0;
    gapless         = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      tbl_label[i] = '0;
      tbl_cost[i]  = '0;
      tbl_busy[i]  = 1'b0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_add_extremes();
    test_alloc_release();
    test_table_full();
    test_output_backpressure();
    test_random();

    // Drain the outstanding responses, then allow for a stray one.
    cmd_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- nearest_free_slot_allocator.f -----
+incdir+rtl
rtl/nfsa_pkg.sv
rtl/nfsa_ram.sv
rtl/nearest_free_slot_allocator.sv
dv/tb_nearest_free_slot_allocator.sv
